// ----- hw/rtl/sha1md_pkg.sv -----
// shared types and constants of the sha-1 digest core
// used by the front, queue, back and top level files; no dependencies
package sha1md_pkg;

    localparam int WORD_W       = 32;
    localparam int BLOCK_WORDS  = 16;
    localparam int ROUNDS       = 80;
    localparam int DIGEST_WORDS = 5;
    localparam int Q_DEPTH      = 4;

    localparam int FILL_W   = $clog2(BLOCK_WORDS);
    localparam int ROUND_W  = $clog2(ROUNDS);
    localparam int IDX_W    = $clog2(DIGEST_WORDS);
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);
    localparam int NB_W     = 3;
    localparam int LEN_W    = 64;

    localparam int ROUND_F2 = 20;
    localparam int ROUND_F3 = 40;
    localparam int ROUND_F4 = 60;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic  is_final;
        word_t data;
    } push_t;

    localparam word_t H_INIT [DIGEST_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam word_t K_F1 = 32'h5A827999;
    localparam word_t K_F2 = 32'h6ED9EBA1;
    localparam word_t K_F3 = 32'h8F1BBCDC;
    localparam word_t K_F4 = 32'hCA62C1D6;

    localparam word_t PAD_MARK = 32'h80000000;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [FILL_W-1:0] LEN_FILL = FILL_W'(BLOCK_WORDS - 2);

endpackage

// ----- hw/rtl/sha1_message_digest_core.sv -----
// top level of the sha-1 message digest core
// joins sha1md_front, sha1md_queue and sha1md_back; uses sha1md_pkg
//
// channel  dir  tdata         tuser        tlast
// s_       in   data_word     valid_bytes  last
// m_       out  digest_word   word_index   last_word
//
// a 16-word block is filled, run through 80 rounds and added into the chaining state
// by the single round unit in the back end, which takes one block at a time
// the final word adds padding and length pushes, one per cycle from the front end while the queue has room
// the front end runs up to four words ahead through the queue
// the digest leaves as five words from an output register while the next
// message fills; a new digest waits only if the previous one is not drained
// reset is synchronous and active low and restores the initial chaining state
module sha1_message_digest_core import sha1md_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [31:0]      s_tdata,   // data_word
    input  logic [NB_W-1:0]  s_tuser,   // valid_bytes
    input  logic             s_tlast,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata,   // digest_word
    output logic [IDX_W-1:0] m_tuser,   // word_index
    output logic             m_tlast
);

    push_t push_item, pop_item;
    logic  push_valid, push_ready, pop_valid, pop_ready;

    sha1md_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .push_item  (push_item),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    sha1md_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_item  (push_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_item   (pop_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    sha1md_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_item  (pop_item),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ----- hw/rtl/sha1md_front.sv -----
// front end: accepts message words, keeps byte count and fill position,
// and turns the final word into padding and length pushes; uses sha1md_pkg
module sha1md_front import sha1md_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [31:0]     s_tdata,    // data_word
    input  logic [NB_W-1:0] s_tuser,    // valid_bytes
    input  logic            s_tlast,
    output push_t           push_item,
    output logic            push_valid,
    input  logic            push_ready
);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_MARK = 4'b0010,
        F_ZERO = 4'b0100,
        F_LEN  = 4'b1000
    } fstate_t;

    fstate_t           state_reg, state_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [LEN_W-1:0]  bytes_reg, bytes_next;
    logic [LEN_W-1:0]  bit_len;
    logic [NB_W-1:0]   nb;

    assign nb       = s_tuser[NB_W-1] ? NB_W'(4) : s_tuser;
    assign bit_len  = {bytes_reg[LEN_W-4:0], 3'b000};
    assign s_tready = (state_reg == F_IDLE) && push_ready;

    always_comb begin
        state_next = state_reg;
        bytes_next = bytes_reg;
        push_valid = 1'b0;
        push_item  = '{is_final: 1'b0, data: '0};
        case (state_reg)
            F_IDLE: begin
                push_valid = s_tvalid;
                push_item.data = s_tdata;
                if (s_tvalid && push_ready) begin
                    if (!s_tlast) begin
                        bytes_next = bytes_reg + LEN_W'(4);
                    end else begin
                        bytes_next = bytes_reg + LEN_W'(nb);
                        state_next = F_ZERO;
                        case (nb)
                            3'd0: push_item.data = PAD_MARK;
                            3'd1: push_item.data = {s_tdata[31:24], PAD_BYTE, 16'h0000};
                            3'd2: push_item.data = {s_tdata[31:16], PAD_BYTE, 8'h00};
                            3'd3: push_item.data = {s_tdata[31:8], PAD_BYTE};
                            default: begin
                                push_item.data = s_tdata;
                                state_next = F_MARK;
                            end
                        endcase
                    end
                end
            end
            F_MARK: begin
                push_valid = 1'b1;
                push_item.data = PAD_MARK;
                if (push_ready) begin
                    state_next = F_ZERO;
                end
            end
            F_ZERO: begin
                push_valid = 1'b1;
                push_item.data = (fill_reg == LEN_FILL) ? bit_len[63:32] : '0;
                if (push_ready && fill_reg == LEN_FILL) begin
                    state_next = F_LEN;
                end
            end
            F_LEN: begin
                push_valid = 1'b1;
                push_item  = '{is_final: 1'b1, data: bit_len[31:0]};
                if (push_ready) begin
                    state_next = F_IDLE;
                    bytes_next = '0;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign fill_next = (push_valid && push_ready) ? fill_reg + FILL_W'(1) : fill_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            fill_reg  <= '0;
            bytes_reg <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            bytes_reg <= bytes_next;
        end
    end

endmodule

// ----- hw/rtl/sha1md_queue.sv -----
// short word queue between front end and compression back end
// uses push_t and queue sizes from sha1md_pkg
module sha1md_queue import sha1md_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  push_t push_item,
    input  logic  push_valid,
    output logic  push_ready,
    output push_t pop_item,
    output logic  pop_valid,
    input  logic  pop_ready
);

    push_t              mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_reg, wr_next;
    logic [Q_PTR_W-1:0] rd_reg, rd_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign push_ready = cnt_reg != Q_CNT_W'(Q_DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_item   = mem_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_next  = do_push ? wr_reg + Q_PTR_W'(1) : wr_reg;
        rd_next  = do_pop ? rd_reg + Q_PTR_W'(1) : rd_reg;
        cnt_next = cnt_reg;
        case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + Q_CNT_W'(1);
            2'b01:   cnt_next = cnt_reg - Q_CNT_W'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_item;
        end
    end

endmodule

// ----- hw/rtl/sha1md_back.sv -----
// back end: block shift register, 80-round compression, chaining state
// and the digest output register; uses sha1md_pkg
module sha1md_back import sha1md_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  push_t            pop_item,
    input  logic             pop_valid,
    output logic             pop_ready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata,   // digest_word
    output logic [IDX_W-1:0] m_tuser,   // word_index
    output logic             m_tlast    // last_word
);

    typedef enum logic [3:0] {
        B_FILL  = 4'b0001,
        B_ROUND = 4'b0010,
        B_ADD   = 4'b0100,
        B_DONE  = 4'b1000
    } bstate_t;

    bstate_t            state_reg, state_next;
    logic [FILL_W-1:0]  cnt_reg, cnt_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic               fin_reg, fin_next;
    word_t              h_reg [DIGEST_WORDS];
    word_t              h_next [DIGEST_WORDS];
    logic               obusy_reg, obusy_next;
    logic [IDX_W-1:0]   oidx_reg, oidx_next;

    word_t              w_reg [BLOCK_WORDS];
    word_t              a_reg, b_reg, c_reg, d_reg, e_reg;
    word_t              out_reg [DIGEST_WORDS];

    word_t              f_val, k_val, t_val, sched, w_new;
    logic               do_pop, fill_done, out_take, out_load;

    assign pop_ready = state_reg == B_FILL;
    assign do_pop    = pop_valid && pop_ready;
    assign fill_done = do_pop && cnt_reg == FILL_W'(BLOCK_WORDS - 1);
    assign out_take  = obusy_reg && m_tready;
    assign out_load  = (state_reg == B_DONE) && !obusy_reg;

    always_comb begin
        if (round_reg < ROUND_W'(ROUND_F2)) begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K_F1;
        end else if (round_reg < ROUND_W'(ROUND_F3)) begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_F2;
        end else if (round_reg < ROUND_W'(ROUND_F4)) begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K_F3;
        end else begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_F4;
        end
        t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_reg[0];
        sched = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        w_new = {sched[30:0], sched[31]};
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        round_next = round_reg;
        fin_next   = fin_reg;
        h_next     = h_reg;
        obusy_next = obusy_reg;
        oidx_next  = oidx_reg;
        case (state_reg)
            B_FILL: begin
                if (do_pop) begin
                    cnt_next = cnt_reg + FILL_W'(1);
                    if (fill_done) begin
                        fin_next   = pop_item.is_final;
                        state_next = B_ROUND;
                    end
                end
            end
            B_ROUND: begin
                round_next = round_reg + ROUND_W'(1);
                if (round_reg == ROUND_W'(ROUNDS - 1)) begin
                    round_next = '0;
                    state_next = B_ADD;
                end
            end
            B_ADD: begin
                h_next[0]  = h_reg[0] + a_reg;
                h_next[1]  = h_reg[1] + b_reg;
                h_next[2]  = h_reg[2] + c_reg;
                h_next[3]  = h_reg[3] + d_reg;
                h_next[4]  = h_reg[4] + e_reg;
                state_next = fin_reg ? B_DONE : B_FILL;
            end
            B_DONE: begin
                if (!obusy_reg) begin
                    h_next     = H_INIT;
                    state_next = B_FILL;
                end
            end
            default: begin
                state_next = B_FILL;
            end
        endcase
        if (out_load) begin
            obusy_next = 1'b1;
            oidx_next  = '0;
        end else if (out_take) begin
            oidx_next = oidx_reg + IDX_W'(1);
            if (oidx_reg == IDX_W'(DIGEST_WORDS - 1)) begin
                obusy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_FILL;
            cnt_reg   <= '0;
            round_reg <= '0;
            fin_reg   <= 1'b0;
            h_reg     <= H_INIT;
            obusy_reg <= 1'b0;
            oidx_reg  <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            round_reg <= round_next;
            fin_reg   <= fin_next;
            h_reg     <= h_next;
            obusy_reg <= obusy_next;
            oidx_reg  <= oidx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_pop || state_reg == B_ROUND) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[BLOCK_WORDS - 1] <= (state_reg == B_ROUND) ? w_new : pop_item.data;
        end
        if (fill_done) begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end else if (state_reg == B_ROUND) begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
        if (out_load) begin
            out_reg <= h_reg;
        end else if (out_take) begin
            for (int i = 0; i < DIGEST_WORDS - 1; i++) begin
                out_reg[i] <= out_reg[i + 1];
            end
        end
    end

    assign m_tvalid = obusy_reg;
    assign m_tdata  = out_reg[0];
    assign m_tuser  = oidx_reg;
    assign m_tlast  = oidx_reg == IDX_W'(DIGEST_WORDS - 1);

    a_round_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == B_ROUND |-> round_reg < ROUND_W'(ROUNDS))
        else $error("round counter out of range");

    a_digest_load: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> obusy_reg && oidx_reg == '0 && state_reg == B_FILL)
        else $error("digest not loaded into output register");

    a_digest_end: assert property (@(posedge aclk) disable iff (!aresetn)
        out_take && m_tlast |=> !obusy_reg)
        else $error("output still busy after last digest word");

    a_no_pop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != B_FILL |-> !pop_ready)
        else $error("queue popped outside block fill");

endmodule

// ----- bench/tb_sha1_message_digest_core.sv -----
// self-checking bench for sha1_message_digest_core: streams messages as words,
// predicts each five-word digest in a scoreboard class and checks the m_ side
// depends on sha1md_pkg and the core rtl
`timescale 1ns / 1ps

module tb_sha1_message_digest_core;
    import sha1md_pkg::*;

    localparam int CLK_HALF   = 4;
    localparam int RESET_CYC  = 11;
    localparam int NUM_ITEMS  = 250;
    localparam int CYCLE_CAP  = 400000;
    localparam int HOLD_CYC   = 3000;
    localparam int DRAIN_CYC  = 400;

    class sha1_scoreboard;
        typedef struct {
            word_t      word;
            logic [2:0] idx;
            logic       lst;
        } digest_word_t;

        word_t          chain [DIGEST_WORDS];
        word_t          blk [BLOCK_WORDS];
        logic [63:0]    nbytes;
        int unsigned    fill;
        digest_word_t   digest_q [$];
        int unsigned    errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < DIGEST_WORDS; i++) chain[i] = H_INIT[i];
            nbytes = '0;
            fill = 0;
        endfunction

        function word_t rotl(word_t v, int n);
            return (v << n) | (v >> (32 - n));
        endfunction

        function void compress();
            word_t w [16];
            word_t a, b, c, d, e, f, k, t;
            for (int i = 0; i < 16; i++) w[i] = blk[i];
            a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
            for (int r = 0; r < ROUNDS; r++) begin
                if (r >= 16) begin
                    w[r % 16] = rotl(w[(r - 3) % 16] ^ w[(r - 8) % 16] ^
                                     w[(r - 14) % 16] ^ w[r % 16], 1);
                end
                if (r < ROUND_F2) begin
                    f = (b & c) | (~b & d);
                    k = K_F1;
                end else if (r < ROUND_F3) begin
                    f = b ^ c ^ d;
                    k = K_F2;
                end else if (r < ROUND_F4) begin
                    f = (b & c) | (b & d) | (c & d);
                    k = K_F3;
                end else begin
                    f = b ^ c ^ d;
                    k = K_F4;
                end
                t = rotl(a, 5) + f + e + k + w[r % 16];
                e = d; d = c; c = rotl(b, 30); b = a; a = t;
            end
            chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
        endfunction

        function void push(word_t w);
            blk[fill] = w;
            fill++;
            if (fill >= BLOCK_WORDS) begin
                compress();
                fill = 0;
            end
        endfunction

        // accepted input word
        function void note_input(word_t dw, logic [2:0] nb, logic lst);
            int unsigned  n;
            word_t        pad;
            logic [63:0]  bitlen;
            digest_word_t ex;
            if (!lst) begin
                nbytes += 64'd4;
                push(dw);
                return;
            end
            n = (nb > 3'd4) ? 4 : int'(nb);
            nbytes += 64'(n);
            if (n == 4) begin
                push(dw);
                pad = PAD_MARK;
            end else if (n == 0) begin
                pad = PAD_MARK;
            end else begin
                pad = (dw & (32'hFFFFFFFF << (32 - 8 * n))) | (32'h80 << (24 - 8 * n));
            end
            push(pad);
            if (fill > 14) push('0);
            while (fill < 14) push('0);
            bitlen = nbytes << 3;
            push(bitlen[63:32]);
            push(bitlen[31:0]);
            for (int i = 0; i < DIGEST_WORDS; i++) begin
                ex.word = chain[i];
                ex.idx  = 3'(i);
                ex.lst  = (i == DIGEST_WORDS - 1);
                digest_q.push_back(ex);
            end
            restart();
        endfunction

        // accepted digest word
        function void check_result(word_t dw, logic [2:0] idx, logic lst);
            digest_word_t ex;
            if (digest_q.size() == 0) begin
                $display("%0t unexpected digest word %h idx %0d last %b",
                         $time, dw, idx, lst);
                errors++;
                return;
            end
            ex = digest_q.pop_front();
            if (dw !== ex.word) begin
                $display("%0t digest_word expected %h actual %h", $time, ex.word, dw);
                errors++;
            end
            if (idx !== ex.idx) begin
                $display("%0t word_index expected %0d actual %0d", $time, ex.idx, idx);
                errors++;
            end
            if (lst !== ex.lst) begin
                $display("%0t last_word expected %b actual %b", $time, ex.lst, lst);
                errors++;
            end
        endfunction

        function int pending();
            return digest_q.size();
        endfunction
    endclass

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [31:0]      s_tdata = '0;
    logic [NB_W-1:0]  s_tuser = '0;
    logic             s_tlast = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [31:0]      m_tdata;
    logic [IDX_W-1:0] m_tuser;
    logic             m_tlast;

    sha1_scoreboard sb = new();
    int  tx_idle = 10;
    int  rx_idle = 84;
    bit  hold_off_req = 1'b0;
    int  words_sent = 0;
    int  cycles = 0;

    sha1_message_digest_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, 3'(m_tuser), m_tlast);
    end

    // receiver ready, with a long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left = HOLD_CYC;
            end
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else begin
                m_tready = ($urandom_range(99) >= rx_idle);
            end
        end
    end

    task automatic send_word(input word_t dw, input logic [2:0] nb, input logic lst);
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = dw;
        s_tuser  = NB_W'(nb);
        s_tlast  = lst;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(dw, nb, lst);
        words_sent++;
    endtask

    task automatic send_message(input int nwords, input logic [2:0] final_nb);
        for (int i = 0; i < nwords; i++) send_word($urandom, 3'($urandom_range(7)), 1'b0);
        send_word($urandom, final_nb, 1'b1);
    endtask

    initial begin
        int nw;
        repeat (RESET_CYC) @(negedge aclk);
        aresetn = 1'b1;

        // empty message, partial and oversized final counts, ignored counts
        send_word(32'hFFFFFFFF, 3'd0, 1'b1);
        send_word(32'hFFFFFFFF, 3'd1, 1'b1);
        send_word(32'hFFFFFFFF, 3'd2, 1'b1);
        send_word(32'hFFFFFFFF, 3'd3, 1'b1);
        send_word(32'h00000000, 3'd4, 1'b1);
        send_word(32'hFFFFFFFF, 3'd5, 1'b1);
        send_word(32'h00000000, 3'd6, 1'b1);
        send_word(32'hFFFFFFFF, 3'd7, 1'b1);
        send_word(32'hFFFFFFFF, 3'd0, 1'b0);
        send_word(32'h00000000, 3'd4, 1'b1);
        send_word(32'h00000000, 3'd7, 1'b0);
        send_word(32'hFFFFFFFF, 3'd3, 1'b1);

        while (words_sent < NUM_ITEMS) begin
            if (words_sent >= NUM_ITEMS / 3 && tx_idle == 10) begin
                tx_idle = 84;
                rx_idle = 10;
            end else if (words_sent >= 2 * NUM_ITEMS / 3 && tx_idle == 84) begin
                tx_idle = 0;
                rx_idle = 0;
                hold_off_req = 1'b1;
            end
            // lengths near the padding boundary get extra weight
            if ($urandom_range(99) < 40) nw = $urandom_range(16, 13);
            else nw = $urandom_range(20);
            send_message(nw, 3'($urandom_range(7)));
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/sha1md_pkg.sv
hw/rtl/sha1md_front.sv
hw/rtl/sha1md_queue.sv
hw/rtl/sha1md_back.sv
hw/rtl/sha1_message_digest_core.sv
bench/tb_sha1_message_digest_core.sv
